// File: design/mclp_pkg.sv
package mclp_pkg;

  localparam int unsigned TURN_DRIVE_W = 30;
  localparam int unsigned MOVE_DRIVE_W = 25;

  typedef struct packed {
    logic               ok;
    logic               too_long;
    logic signed [15:0] turn;
    logic signed [15:0] move;
  } mclp_res_t;

endpackage

// File: design/mclp_parser.sv
module mclp_parser
  import mclp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       byte_taken_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output mclp_res_t  res_o
);

  localparam int unsigned LenW = $clog2(LINE_MAX + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_MAX);

  localparam logic [3:0] PhPrefix = 4'd0;
  localparam logic [3:0] PhWs1    = 4'd1;
  localparam logic [3:0] PhSign1  = 4'd2;
  localparam logic [3:0] PhDig1   = 4'd3;
  localparam logic [3:0] PhWs2    = 4'd4;
  localparam logic [3:0] PhSign2  = 4'd5;
  localparam logic [3:0] PhDig2   = 4'd6;
  localparam logic [3:0] PhDone   = 4'd7;
  localparam logic [3:0] PhFail   = 4'd8;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharNl    = 8'h0a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef struct packed {
    logic [3:0]  phase;
    logic        neg;
    logic [16:0] second;
  } sec_t;

  function automatic logic [7:0] keyword_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h6d;
      3'd1:    ch = 8'h6f;
      3'd2:    ch = 8'h76;
      3'd3:    ch = 8'h65;
      default: ch = CharSpace;
    endcase
    return ch;
  endfunction

  function automatic logic [16:0] add_digit(input logic [16:0] mag, input logic [7:0] ch);
    logic [20:0] m;
    m = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {17'd0, ch[3:0]};
    return (m > 21'd32768) ? 17'd32768 : m[16:0];
  endfunction

  function automatic logic [15:0] signed_sat(input logic [16:0] mag, input logic neg);
    logic [16:0] m;
    logic [16:0] v;
    if (neg) begin
      m = (mag > 17'd32768) ? 17'd32768 : mag;
      v = -m;
    end else begin
      m = (mag > 17'd32767) ? 17'd32767 : mag;
      v = m;
    end
    return v[15:0];
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CharSpace) || (ch >= 8'h09 && ch <= 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CharZero) && (ch <= CharNine);
  endfunction

  function automatic sec_t before_second(input logic [7:0] ch, input logic neg,
                                         input logic [16:0] second);
    sec_t s;
    s.phase  = PhFail;
    s.neg    = neg;
    s.second = second;
    if (is_space(ch)) begin
      s.phase = PhWs2;
    end else if (ch == CharPlus || ch == CharMinus) begin
      s.neg   = (ch == CharMinus);
      s.phase = PhSign2;
    end else if (is_digit(ch)) begin
      s.neg    = 1'b0;
      s.second = add_digit(17'd0, ch);
      s.phase  = PhDig2;
    end
    return s;
  endfunction

  logic [3:0]      phase_q, phase_d;
  logic [2:0]      prefix_idx_q, prefix_idx_d;
  logic            neg_q, neg_d;
  logic [16:0]     first_q, first_d;
  logic [16:0]     second_q, second_d;
  logic [LenW-1:0] len_q, len_d;
  logic            overflow_q, overflow_d;
  logic            text_ended_q, text_ended_d;

  logic            res_valid_q;
  mclp_res_t       res_q, res_d;
  logic            s2_ready;
  logic            is_nl;
  logic            consume;
  logic            line_ok;
  logic [15:0]     first_sat;
  sec_t            sec;

  assign s2_ready     = !res_valid_q || res_ready_i;
  assign is_nl        = (byte_i == CharNl);
  assign consume      = byte_valid_i && (!is_nl || s2_ready);
  assign byte_taken_o = consume;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign line_ok   = !overflow_q && (phase_q == PhDig2 || phase_q == PhDone);
  assign first_sat = signed_sat(first_q, neg_q);
  assign sec       = before_second(byte_i, (phase_q == PhDig1) ? 1'b0 : neg_q, second_q);

  always_comb begin
    res_d.ok       = line_ok;
    res_d.too_long = overflow_q;
    res_d.turn     = line_ok ? first_q[15:0] : 16'sd0;
    res_d.move     = line_ok ? signed_sat(second_q, neg_q) : 16'sd0;
  end

  always_comb begin
    phase_d      = phase_q;
    prefix_idx_d = prefix_idx_q;
    neg_d        = neg_q;
    first_d      = first_q;
    second_d     = second_q;
    len_d        = len_q;
    overflow_d   = overflow_q;
    text_ended_d = text_ended_q;
    if (consume) begin
      if (is_nl) begin
        phase_d      = PhPrefix;
        prefix_idx_d = 3'd0;
        neg_d        = 1'b0;
        first_d      = 17'd0;
        second_d     = 17'd0;
        len_d        = '0;
        overflow_d   = 1'b0;
        text_ended_d = 1'b0;
      end else begin
        if (len_q < LenMax) begin
          len_d = len_q + LenW'(1);
        end
        overflow_d = overflow_q || (len_d == LenMax);
        if (byte_i == CharNul) begin
          text_ended_d = 1'b1;
        end else if (!text_ended_q) begin
          unique case (phase_q)
            PhPrefix: begin
              if (prefix_idx_q < 3'd5 && byte_i == keyword_char(prefix_idx_q)) begin
                prefix_idx_d = prefix_idx_q + 3'd1;
                if (prefix_idx_q == 3'd4) begin
                  phase_d = PhWs1;
                end
              end else begin
                phase_d = PhFail;
              end
            end
            PhWs1: begin
              if (is_space(byte_i)) begin
                phase_d = PhWs1;
              end else if (byte_i == CharPlus || byte_i == CharMinus) begin
                neg_d   = (byte_i == CharMinus);
                phase_d = PhSign1;
              end else if (is_digit(byte_i)) begin
                neg_d   = 1'b0;
                first_d = add_digit(17'd0, byte_i);
                phase_d = PhDig1;
              end else begin
                phase_d = PhFail;
              end
            end
            PhSign1, PhDig1: begin
              if (is_digit(byte_i)) begin
                first_d = add_digit(first_q, byte_i);
                phase_d = PhDig1;
              end else if (phase_q == PhDig1) begin
                first_d  = {first_sat[15], first_sat};
                phase_d  = sec.phase;
                neg_d    = sec.neg;
                second_d = sec.second;
              end else begin
                phase_d = PhFail;
              end
            end
            PhWs2: begin
              phase_d  = sec.phase;
              neg_d    = sec.neg;
              second_d = sec.second;
            end
            PhSign2, PhDig2: begin
              if (is_digit(byte_i)) begin
                second_d = add_digit(second_q, byte_i);
                phase_d  = PhDig2;
              end else begin
                phase_d = (phase_q == PhDig2) ? PhDone : PhFail;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhPrefix;
      prefix_idx_q <= 3'd0;
      neg_q        <= 1'b0;
      first_q      <= 17'd0;
      second_q     <= 17'd0;
      len_q        <= '0;
      overflow_q   <= 1'b0;
      text_ended_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      prefix_idx_q <= prefix_idx_d;
      neg_q        <= neg_d;
      first_q      <= first_d;
      second_q     <= second_d;
      len_q        <= len_d;
      overflow_q   <= overflow_d;
      text_ended_q <= text_ended_d;
      if (s2_ready) begin
        res_valid_q <= consume && is_nl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && is_nl) begin
      res_q <= res_d;
    end
  end

endmodule

// File: design/mclp_drive.sv
module mclp_drive
  import mclp_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           res_valid_i,
  output logic                           res_ready_o,
  input  mclp_res_t                      res_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           line_ok_o,
  output logic                           line_too_long_o,
  output logic signed [15:0]             turn_value_o,
  output logic signed [15:0]             move_value_o,
  output logic signed [MOVE_DRIVE_W-1:0] move_drive_o,
  output logic signed [TURN_DRIVE_W-1:0] turn_drive_o
);

  // round(mag * 9830.4) = mag * 9830 + round(mag * 0.4)
  // round(mag * 458.752) = mag * 458 + round(mag * 0.752)
  localparam int unsigned TurnInt   = 9830;
  localparam int unsigned TurnFracK = 419431;
  localparam int unsigned TurnHalf  = 524288;
  localparam int unsigned MoveInt   = 458;
  localparam int unsigned MoveFracK = 12616467;
  localparam int unsigned MoveHalf  = 8388608;

  logic        s3_valid_q;
  mclp_res_t   s3_res_q;
  logic [28:0] tbase_q, tbase_d;
  logic [14:0] tfrac_q, tfrac_d;
  logic [23:0] mbase_q, mbase_d;
  logic [15:0] mfrac_q, mfrac_d;

  logic        out_valid_q;
  logic        out_ready;
  logic        s3_ready;

  logic [15:0] tmag, mmag;
  logic [34:0] tprod;
  logic [39:0] mprod;
  logic [28:0] tsum;
  logic [23:0] msum;

  logic                           ok_q, too_long_q;
  logic signed [15:0]             turn_q, move_q;
  logic signed [MOVE_DRIVE_W-1:0] md_q, md_d;
  logic signed [TURN_DRIVE_W-1:0] td_q, td_d;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s3_ready    = !s3_valid_q || out_ready;
  assign res_ready_o = s3_ready;

  assign tmag = res_i.turn[15] ? (~res_i.turn + 16'd1) : res_i.turn;
  assign mmag = res_i.move[15] ? (~res_i.move + 16'd1) : res_i.move;

  assign tprod   = 35'(tmag) * 35'(TurnFracK) + 35'(TurnHalf);
  assign mprod   = 40'(mmag) * 40'(MoveFracK) + 40'(MoveHalf);
  assign tbase_d = 29'(tmag) * 29'(TurnInt);
  assign mbase_d = 24'(mmag) * 24'(MoveInt);
  assign tfrac_d = tprod[34:20];
  assign mfrac_d = mprod[39:24];

  // drives carry the opposite sign of the values
  assign tsum = tbase_q + 29'(tfrac_q);
  assign msum = mbase_q + 24'(mfrac_q);
  assign td_d = s3_res_q.turn[15] ? {1'b0, tsum} : -{1'b0, tsum};
  assign md_d = s3_res_q.move[15] ? {1'b0, msum} : -{1'b0, msum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= res_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && s3_ready) begin
      s3_res_q <= res_i;
      tbase_q  <= tbase_d;
      tfrac_q  <= tfrac_d;
      mbase_q  <= mbase_d;
      mfrac_q  <= mfrac_d;
    end
    if (s3_valid_q && out_ready) begin
      ok_q       <= s3_res_q.ok;
      too_long_q <= s3_res_q.too_long;
      turn_q     <= s3_res_q.turn;
      move_q     <= s3_res_q.move;
      td_q       <= td_d;
      md_q       <= md_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_ok_o       = ok_q;
  assign line_too_long_o = too_long_q;
  assign turn_value_o    = turn_q;
  assign move_value_o    = move_q;
  assign move_drive_o    = md_q;
  assign turn_drive_o    = td_q;

endmodule

// File: design/move_command_line_parser.sv
// Parses "move <turn> <move>" command lines from a byte stream, one byte per cycle
// while in_stall_o is low. Every newline gives one result: the ok and too-long flags,
// both integers saturated to 16-bit signed, and the drive values -move*0.007 and
// -turn*0.15 in signed Q.16, rounded to nearest with ties away from zero. Lines of
// LINE_MAX or more bytes before the newline are rejected, and a NUL byte ends the
// parsed text. in_stall_o is raised only while a newline waits for the parse result
// register. A result passes the input register, parse result register, multiplier
// register and output register, and results stay in order under any stall pattern.
module move_command_line_parser
  import mclp_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           line_ok_o,
  output logic                           line_too_long_o,
  output logic signed [15:0]             turn_value_o,
  output logic signed [15:0]             move_value_o,
  output logic signed [MOVE_DRIVE_W-1:0] move_drive_o,
  output logic signed [TURN_DRIVE_W-1:0] turn_drive_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_ready;
  logic       byte_taken;
  logic       res_valid;
  logic       res_ready;
  mclp_res_t  res;

  assign s1_ready   = !s1_valid_q || byte_taken;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  mclp_parser #(
    .LINE_MAX(LINE_MAX)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s1_valid_q),
    .byte_i      (s1_byte_q),
    .byte_taken_o(byte_taken),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  mclp_drive u_drive (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_ok_o      (line_ok_o),
    .line_too_long_o(line_too_long_o),
    .turn_value_o   (turn_value_o),
    .move_value_o   (move_value_o),
    .move_drive_o   (move_drive_o),
    .turn_drive_o   (turn_drive_o)
  );

endmodule

// File: design/mclp_checker.sv
module mclp_checker
  import mclp_pkg::*;
(
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           line_ok_o,
  input logic                           line_too_long_o,
  input logic signed [15:0]             turn_value_o,
  input logic signed [15:0]             move_value_o,
  input logic signed [MOVE_DRIVE_W-1:0] move_drive_o,
  input logic signed [TURN_DRIVE_W-1:0] turn_drive_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_ok_o) &&
    $stable(turn_drive_o) && $stable(move_drive_o) && $stable(turn_value_o))
    else $error("result changed while stalled");

  a_ok_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_ok_o && line_too_long_o))
    else $error("overlong line flagged ok");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_ok_o |-> turn_value_o == 16'sd0 && move_value_o == 16'sd0 &&
    move_drive_o == '0 && turn_drive_o == '0)
    else $error("rejected line carries nonzero fields");

  a_turn_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_ok_o && turn_value_o != 16'sd0 |->
    turn_drive_o[TURN_DRIVE_W-1] != turn_value_o[15])
    else $error("turn drive sign mismatch");

  a_move_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_ok_o && move_value_o != 16'sd0 |->
    move_drive_o[MOVE_DRIVE_W-1] != move_value_o[15])
    else $error("move drive sign mismatch");

endmodule

bind move_command_line_parser mclp_checker u_mclp_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mclp_pkg::*;

  localparam int LINE_MAX = 64;

  typedef enum logic [3:0] {
    P_KEYWORD, P_GAP1, P_SIGN1, P_NUM1, P_GAP2, P_SIGN2, P_NUM2, P_TAIL, P_BAD
  } parse_phase_e;

  typedef enum logic [1:0] {LK_PREDICT, LK_REJECT, LK_OVERLONG, LK_ZERO} line_kind_e;

  typedef struct packed {
    mclp_res_t                      head;
    logic signed [MOVE_DRIVE_W-1:0] mdrv;
    logic signed [TURN_DRIVE_W-1:0] tdrv;
  } line_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     rx_byte_i = 8'h00;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           line_ok_o;
  logic                           line_too_long_o;
  logic signed [15:0]             turn_value_o;
  logic signed [15:0]             move_value_o;
  logic signed [MOVE_DRIVE_W-1:0] move_drive_o;
  logic signed [TURN_DRIVE_W-1:0] turn_drive_o;

  move_command_line_parser #(.LINE_MAX(LINE_MAX)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_ok_o      (line_ok_o),
    .line_too_long_o(line_too_long_o),
    .turn_value_o   (turn_value_o),
    .move_value_o   (move_value_o),
    .move_drive_o   (move_drive_o),
    .turn_drive_o   (turn_drive_o)
  );

  always #5 clk_i = ~clk_i;

  // parser copy
  parse_phase_e phase = P_KEYWORD;
  int           kw_idx = 0;
  bit           neg = 1'b0;
  int           num1 = 0;
  int           num2 = 0;
  int           len = 0;
  bit           over = 1'b0;
  bit           nul_seen = 1'b0;
  string        kw_text = "move ";

  logic [7:0]   rx_stream[$];
  line_kind_e   line_kind_q[$];
  line_result_t pending_cmds[$];
  logic [7:0]   ln[$];

  int           bytes_total = 0;
  int           bytes_taken = 0;
  int           calm_from = 0;
  int           rx_gap = 0;
  int           stall_gap = 0;
  int           n_bad = 0;
  int           lines_seen = 0;
  int           lines_ok = 0;
  int           lines_long = 0;
  bit           line_done;
  line_kind_e   kind;
  line_result_t predicted;
  line_result_t want;

  string        dir_text[22] = '{
    "", "move 0 0", "move 1 1", "move 32767 -32768", "move -32768 32767",
    "move 99999 -1234567", "move 5-3", "move \t +12\t\t-7 and more", "move 00012 -0",
    "move +5 +6", "move - 3", "move 5 +", "move 1", "mov 1 2", "Move 1 2", "move x 1",
    "move 3 4 junk", "move 3 4", "move 2 3", "move 2 3", "move 2 3", "move -9 9"
  };
  int           dir_pad[22] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                 0, 0, 55, 56, 190, 0};
  int           dir_nul[22] = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                                 -1, -1, 8, 6, -1, -1, -1, -1};
  line_kind_e   dir_kind[22] = '{
    LK_REJECT, LK_ZERO, LK_PREDICT, LK_PREDICT, LK_PREDICT, LK_PREDICT, LK_PREDICT,
    LK_PREDICT, LK_PREDICT, LK_PREDICT, LK_REJECT, LK_REJECT, LK_REJECT, LK_REJECT,
    LK_REJECT, LK_REJECT, LK_PREDICT, LK_REJECT, LK_PREDICT, LK_OVERLONG, LK_OVERLONG,
    LK_PREDICT
  };

  function automatic bit blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int push_digit(input int m, input logic [7:0] c);
    int r;
    r = m * 10 + (int'(c) - 48);
    return (r > 32768) ? 32768 : r;
  endfunction

  function automatic int clamp16(input int m, input bit is_neg);
    if (is_neg) return -((m > 32768) ? 32768 : m);
    return (m > 32767) ? 32767 : m;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint scaled(input int v, input longint num, input longint den);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag * num * 2 + den) / (2 * den);
    return (v < 0) ? -q : q;
  endfunction

  task automatic second_start(input logic [7:0] c);
    if (blank(c)) begin
      phase = P_GAP2;
    end else if (c == "+" || c == "-") begin
      neg = (c == "-");
      phase = P_SIGN2;
    end else if (numeral(c)) begin
      neg = 1'b0;
      num2 = push_digit(0, c);
      phase = P_NUM2;
    end else begin
      phase = P_BAD;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (phase)
      P_KEYWORD: begin
        if (kw_idx < 5 && c == kw_text[kw_idx]) begin
          kw_idx++;
          if (kw_idx == 5) phase = P_GAP1;
        end else begin
          phase = P_BAD;
        end
      end
      P_GAP1: begin
        if (!blank(c)) begin
          if (c == "+" || c == "-") begin
            neg = (c == "-");
            phase = P_SIGN1;
          end else if (numeral(c)) begin
            neg = 1'b0;
            num1 = push_digit(0, c);
            phase = P_NUM1;
          end else begin
            phase = P_BAD;
          end
        end
      end
      P_SIGN1, P_NUM1: begin
        if (numeral(c)) begin
          num1 = push_digit(num1, c);
          phase = P_NUM1;
        end else if (phase == P_NUM1) begin
          num1 = clamp16(num1, neg);
          neg = 1'b0;
          second_start(c);
        end else begin
          phase = P_BAD;
        end
      end
      P_GAP2: second_start(c);
      P_SIGN2, P_NUM2: begin
        if (numeral(c)) begin
          num2 = push_digit(num2, c);
          phase = P_NUM2;
        end else begin
          phase = (phase == P_NUM2) ? P_TAIL : P_BAD;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] c, output bit done, output line_result_t r);
    int tn;
    int mv;
    r = '0;
    done = 1'b0;
    if (c != 8'h0a) begin
      if (len < LINE_MAX) len++;
      if (len >= LINE_MAX) over = 1'b1;
      if (c == 8'h00) nul_seen = 1'b1;
      else if (!nul_seen) parse_char(c);
    end else begin
      done = 1'b1;
      r.head.too_long = over;
      r.head.ok = !over && (phase == P_NUM2 || phase == P_TAIL);
      if (r.head.ok) begin
        tn = num1;
        mv = clamp16(num2, neg);
        r.head.turn = 16'(tn);
        r.head.move = 16'(mv);
        r.mdrv = MOVE_DRIVE_W'(scaled(-mv, 458752, 1000));
        r.tdrv = TURN_DRIVE_W'(scaled(-tn, 98304, 10));
      end
      phase = P_KEYWORD;
      kw_idx = 0;
      neg = 1'b0;
      num1 = 0;
      num2 = 0;
      len = 0;
      over = 1'b0;
      nul_seen = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      n_bad++;
    end
  endtask

  // stimulus building
  task automatic send_byte(input logic [7:0] b, input line_kind_e k);
    rx_stream.push_back(b);
    if (b == 8'h0a) line_kind_q.push_back(k);
  endtask

  task automatic ship_line(input line_kind_e k);
    ln.push_back(8'h0a);
    foreach (ln[i]) send_byte(ln[i], k);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) ln.push_back(s[i]);
  endtask

  task automatic put_ws(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(13, 8));
      if (b == 8'd8 || b == 8'd10) b = 8'd32;
      ln.push_back(b);
    end
  endtask

  task automatic put_junk(input int n);
    repeat (n) ln.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_number();
    int s;
    int nd;
    s = $urandom_range(3);
    if (s == 0) ln.push_back("-");
    else if (s == 1) ln.push_back("+");
    nd = ($urandom_range(7) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 1);
    repeat (nd) ln.push_back(8'($urandom_range(57, 48)));
  endtask

  task automatic random_line();
    int sel;
    ln.delete();
    sel = $urandom_range(99);
    if (sel < 85) begin
      put_text("move ");
      put_ws($urandom_range(2));
      put_number();
      if ($urandom_range(3) != 0) put_ws($urandom_range(2, 1));
      put_number();
      case ($urandom_range(3))
        0: begin
        end
        1: begin
          put_ws(1);
          put_text("go");
        end
        2: begin
          ln.push_back(8'h00);
          put_junk($urandom_range(6));
        end
        default: put_junk($urandom_range(4));
      endcase
      // broken command: one byte overwritten
      if (sel >= 70) ln[$urandom_range(ln.size() - 1)] = 8'($urandom_range(255));
    end else if (sel < 95) begin
      put_junk($urandom_range(20, 1));
    end else begin
      put_text("move 1 2");
      put_junk((($urandom_range(3) == 0) ? $urandom_range(120, 60) : $urandom_range(66, 54))
               - 8);
    end
    ship_line(LK_PREDICT);
  endtask

  // byte transfers in, result transfers out
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        take_byte(rx_byte_i, line_done, predicted);
        if (line_done) begin
          kind = line_kind_q.pop_front();
          if (kind != LK_PREDICT) begin
            predicted = '0;
            predicted.head.ok = (kind == LK_ZERO);
            predicted.head.too_long = (kind == LK_OVERLONG);
          end
          pending_cmds.push_back(predicted);
        end
        bytes_taken++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (rx_gap > 0) begin
          rx_gap--;
          in_valid_i <= 1'b0;
        end else if (bytes_taken < calm_from && $urandom_range(9) == 0) begin
          rx_gap = $urandom_range(8);
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= rx_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end

      if (out_valid_o && !out_stall_i) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t unexpected result: expected none, got ok %0d too_long %0d",
                   $time, line_ok_o, line_too_long_o);
          n_bad++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("line_ok", want.head.ok, line_ok_o);
          check_field("line_too_long", want.head.too_long, line_too_long_o);
          check_field("turn_value", want.head.turn, turn_value_o);
          check_field("move_value", want.head.move, move_value_o);
          check_field("move_drive", want.mdrv, move_drive_o);
          check_field("turn_drive", want.tdrv, turn_drive_o);
          lines_seen++;
          if (want.head.ok) lines_ok++;
          if (want.head.too_long) lines_long++;
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall_i <= 1'b1;
      end else if (bytes_taken < calm_from && $urandom_range(9) == 0) begin
        stall_gap = $urandom_range(8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int k;
    foreach (dir_text[i]) begin
      ln.delete();
      put_text(dir_text[i]);
      if (dir_nul[i] >= 0) ln.insert(dir_nul[i], 8'h00);
      repeat (dir_pad[i]) ln.push_back("x");
      ship_line(dir_kind[i]);
    end
    while (rx_stream.size() < 1000) random_line();
    bytes_total = rx_stream.size();
    calm_from = bytes_total - 150;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < bytes_total) @(posedge clk_i);
    k = 0;
    while (pending_cmds.size() != 0 && k < 5000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_cmds.size() != 0) begin
      $display("%0t results missing: expected %0d more, got none", $time, pending_cmds.size());
      n_bad += pending_cmds.size();
    end

    $display("sent %0d bytes under random idle and stall, checked %0d lines", bytes_total,
             lines_seen);
    $display("%0d valid commands, %0d overlong lines, %0d mismatches", lines_ok, lines_long,
             n_bad);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
